// File: hw/rtl/modexp_pkg.sv
// modexp_pkg: shared types, step numbers and the microcode table of the
// modular exponentiation block. No dependencies; imported by every module.
`default_nettype none

package modexp_pkg;

  // default operand width
  localparam int unsigned ModWidthDefault = 16;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MODULUS  = 2'd1;

  // microprogram step numbers
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] S_INIT  = 4'd0;
  localparam logic [StepW-1:0] S_LOAD  = 4'd1;
  localparam logic [StepW-1:0] S_RBAS  = 4'd2;
  localparam logic [StepW-1:0] S_TEST  = 4'd3;
  localparam logic [StepW-1:0] S_BIT   = 4'd4;
  localparam logic [StepW-1:0] S_MUL   = 4'd5;
  localparam logic [StepW-1:0] S_RACC  = 4'd6;
  localparam logic [StepW-1:0] S_SQR   = 4'd7;
  localparam logic [StepW-1:0] S_RSQR  = 4'd8;
  localparam logic [StepW-1:0] S_ZERO  = 4'd9;
  localparam logic [StepW-1:0] S_DONE  = 4'd10;

  // sequencing condition of a step
  typedef enum logic [2:0] {
    J_NEXT    = 3'd0,
    J_ALWAYS  = 3'd1,
    J_MOD_LT2 = 3'd2,
    J_EX_ZERO = 3'd3,
    J_BIT_CLR = 3'd4,
    J_END     = 3'd5
  } modexp_jmp_e;

  typedef enum logic {OPA_ACC = 1'b0, OPA_BASE = 1'b1} modexp_opa_e;
  typedef enum logic {OPB_ONE = 1'b0, OPB_BASE = 1'b1} modexp_opb_e;
  typedef enum logic {DST_ACC = 1'b0, DST_BASE = 1'b1} modexp_dst_e;

  // one control word
  typedef struct packed {
    logic             init;      // acc = 1, ex = exponent
    logic             zero;      // acc = 0
    logic             mul;       // register product of the two operands
    modexp_opa_e      opa;
    modexp_opb_e      opb;
    logic             red;       // reduce product, hold until done
    modexp_dst_e      dst;
    logic             shift_ex;  // drop low exponent bit at end of step
    logic             out;       // load output register, hold until free
    modexp_jmp_e      jmp;
    logic [StepW-1:0] target;
  } modexp_ucw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic mod_lt2;
    logic ex_zero;
    logic ex_bit0;
    logic red_done;
    logic out_free;
  } modexp_stat_t;

  // sequencer status seen by the datapath
  typedef struct packed {
    logic busy;
    logic first;   // first cycle of the current step
  } modexp_seq_t;

  // microprogram: right-to-left square and multiply
  function automatic modexp_ucw_t modexp_ucode(input logic [StepW-1:0] pc);
    modexp_ucw_t w;
    w = '0;
    case (pc)
      S_INIT: begin
        w.init = 1'b1; w.jmp = J_MOD_LT2; w.target = S_ZERO;
      end
      S_LOAD: begin
        w.mul = 1'b1; w.opa = OPA_BASE; w.opb = OPB_ONE;
      end
      S_RBAS: begin
        w.red = 1'b1; w.dst = DST_BASE;
      end
      S_TEST: begin
        w.jmp = J_EX_ZERO; w.target = S_DONE;
      end
      S_BIT: begin
        w.jmp = J_BIT_CLR; w.target = S_SQR;
      end
      S_MUL: begin
        w.mul = 1'b1; w.opa = OPA_ACC; w.opb = OPB_BASE;
      end
      S_RACC: begin
        w.red = 1'b1; w.dst = DST_ACC;
      end
      S_SQR: begin
        w.mul = 1'b1; w.opa = OPA_BASE; w.opb = OPB_BASE;
      end
      S_RSQR: begin
        w.red = 1'b1; w.dst = DST_BASE; w.shift_ex = 1'b1;
        w.jmp = J_ALWAYS; w.target = S_TEST;
      end
      S_ZERO: begin
        w.zero = 1'b1; w.jmp = J_ALWAYS; w.target = S_DONE;
      end
      S_DONE: begin
        w.out = 1'b1; w.jmp = J_END;
      end
      default: begin
        w.jmp = J_END;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/modular_exponentiation.sv
// modular_exponentiation: top level with config registers, datapath
// registers and output register. Depends on modexp_pkg, modexp_seq,
// modexp_mul and modexp_red.
`default_nettype none

// Each input beat carries one ciphertext word (tdata) and a last flag (tlast);
// the block returns ciphertext^exponent mod modulus with the flag copied, one
// output beat per input beat, in order. A zero exponent gives 1, a modulus
// below two gives 0. Exponent (index 0) and modulus (index 1) are written
// over the cfg channel; the user must do so only while the block is idle,
// which the block itself does not enforce. Words are handled one at a time;
// the shift-subtract reducer retires one bit of each double-width product per
// cycle. A new word is accepted as soon as the previous result sits in the
// output register.
module modular_exponentiation #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::ModWidthDefault,
  parameter int unsigned DATA_W    = ((MOD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // config write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [modexp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [MOD_WIDTH-1:0]             cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [DATA_W-1:0]                s_axis_tdata,  // ciphertext
  input  wire logic                             s_axis_tlast,  // last_item
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [DATA_W-1:0]                m_axis_tdata,  // plaintext
  output logic                                  m_axis_tlast   // last_out
);
  import modexp_pkg::*;

  localparam int unsigned ProdW = 2 * MOD_WIDTH;

  logic [MOD_WIDTH-1:0] exponent_q;
  logic [MOD_WIDTH-1:0] modulus_q;
  logic [MOD_WIDTH-1:0] acc_q;
  logic [MOD_WIDTH-1:0] base_q;
  logic [MOD_WIDTH-1:0] ex_q;
  logic                 last_q;
  logic                 out_valid_q;
  logic [MOD_WIDTH-1:0] out_data_q;
  logic                 out_last_q;

  logic                 in_accept;
  logic                 cfg_accept;
  logic                 act;
  logic                 out_free;
  logic                 out_load;
  logic                 red_start;
  logic                 red_done;
  logic                 red_write;
  logic [MOD_WIDTH-1:0] red_rem;
  logic [MOD_WIDTH-1:0] opa;
  logic [MOD_WIDTH-1:0] opb;
  logic [ProdW-1:0]     prod;

  modexp_ucw_t  ucw;
  modexp_seq_t  seq;
  modexp_stat_t stat;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = !seq.busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign act           = seq.busy;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = act && ucw.out && out_free;
  assign red_start     = act && ucw.red && seq.first;
  assign red_write     = act && ucw.red && red_done;

  // status for the sequencer
  assign stat.mod_lt2  = (modulus_q < MOD_WIDTH'(2));
  assign stat.ex_zero  = (ex_q == '0);
  assign stat.ex_bit0  = ex_q[0];
  assign stat.red_done = red_done;
  assign stat.out_free = out_free;

  modexp_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .stat_i  (stat),
    .ucw_o   (ucw),
    .seq_o   (seq)
  );

  // multiplier operand select
  assign opa = (ucw.opa == OPA_ACC) ? acc_q : base_q;
  assign opb = (ucw.opb == OPB_ONE) ? MOD_WIDTH'(1) : base_q;

  modexp_mul #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk_i  (clk_i),
    .en_i   (act && ucw.mul),
    .a_i    (opa),
    .b_i    (opb),
    .prod_o (prod)
  );

  modexp_red #(.MOD_WIDTH(MOD_WIDTH)) u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .prod_i  (prod),
    .mod_i   (modulus_q),
    .done_o  (red_done),
    .rem_o   (red_rem)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= '0;
      modulus_q  <= MOD_WIDTH'(2);
    end else if (cfg_accept) begin
      case (cfg_index_i)
        REG_EXPONENT: exponent_q <= cfg_data_i;
        REG_MODULUS:  modulus_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath registers driven by the control word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_q <= s_axis_tdata[MOD_WIDTH-1:0];
      last_q <= s_axis_tlast;
    end
    if (act && ucw.init) begin
      acc_q <= MOD_WIDTH'(1);
      ex_q  <= exponent_q;
    end
    if (act && ucw.zero) begin
      acc_q <= '0;
    end
    if (red_write) begin
      if (ucw.dst == DST_ACC) begin
        acc_q <= red_rem;
      end else begin
        base_q <= red_rem;
      end
      if (ucw.shift_ex) begin
        ex_q <= ex_q >> 1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= acc_q;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // a new word locks the input side on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  // every reduction ends below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (red_rem < modulus_q))
    else $error("reducer remainder not below modulus");

  // a result leaves reduced, or is the zero of a degenerate modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ((acc_q < modulus_q) || (modulus_q < MOD_WIDTH'(2))))
    else $error("result not reduced");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/modexp_mul.sv
// modexp_mul: registered full-width multiplier of the exponentiation datapath.
// Depends on modexp_pkg.
`default_nettype none

module modexp_mul #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::ModWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [MOD_WIDTH-1:0]   a_i,
  input  wire logic [MOD_WIDTH-1:0]   b_i,
  output logic      [2*MOD_WIDTH-1:0] prod_o
);
  import modexp_pkg::*;

  localparam int unsigned ProdW = 2 * MOD_WIDTH;

  logic [ProdW-1:0] prod_q;

  // double-width product, held until the next multiply
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: hw/rtl/modexp_red.sv
// modexp_red: shift-subtract reduction of a double-width product modulo the
// modulus, one quotient bit per cycle. Depends on modexp_pkg.
`default_nettype none

module modexp_red #(
  parameter int unsigned MOD_WIDTH = modexp_pkg::ModWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [2*MOD_WIDTH-1:0] prod_i,
  input  wire logic [MOD_WIDTH-1:0]   mod_i,
  output logic                        done_o,
  output logic      [MOD_WIDTH-1:0]   rem_o
);
  import modexp_pkg::*;

  localparam int unsigned ProdW = 2 * MOD_WIDTH;
  localparam int unsigned CntW  = $clog2(ProdW + 1);

  logic [CntW-1:0]      cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [MOD_WIDTH-1:0] rem_q;
  logic [MOD_WIDTH-1:0] rem_d;
  logic [ProdW-1:0]     sh_q;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   mod_ext;

  // one restoring step: shift in next product bit, subtract if it fits
  always_comb begin
    mod_ext = {1'b0, mod_i};
    trial   = {rem_q, sh_q[ProdW-1]};
    if (trial >= mod_ext) begin
      rem_d = MOD_WIDTH'(trial - mod_ext);
    end else begin
      rem_d = MOD_WIDTH'(trial);
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(ProdW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // partial remainder and product shifter
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= prod_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[ProdW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/modexp_seq.sv
// modexp_seq: step counter and microcode sequencer with conditional jumps.
// Depends on modexp_pkg for the control word and the program table.
`default_nettype none

module modexp_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire modexp_pkg::modexp_stat_t   stat_i,
  output modexp_pkg::modexp_ucw_t         ucw_o,
  output modexp_pkg::modexp_seq_t         seq_o
);
  import modexp_pkg::*;

  logic [StepW-1:0] pc_q, pc_d;
  logic             busy_q, busy_d;
  logic             first_q, first_d;
  logic             hold;
  logic             taken;
  modexp_ucw_t      ucw;

  assign ucw = modexp_ucode(pc_q);

  // stall while the reducer or the output register is not ready
  assign hold = (ucw.red && !stat_i.red_done) || (ucw.out && !stat_i.out_free);

  // jump condition
  always_comb begin
    case (ucw.jmp)
      J_NEXT:    taken = 1'b0;
      J_ALWAYS:  taken = 1'b1;
      J_MOD_LT2: taken = stat_i.mod_lt2;
      J_EX_ZERO: taken = stat_i.ex_zero;
      J_BIT_CLR: taken = !stat_i.ex_bit0;
      default:   taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    pc_d    = pc_q;
    busy_d  = busy_q;
    first_d = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d  = 1'b1;
        pc_d    = S_INIT;
        first_d = 1'b1;
      end
    end else if (!hold) begin
      if (ucw.jmp == J_END) begin
        busy_d = 1'b0;
        pc_d   = S_INIT;
      end else begin
        first_d = 1'b1;
        pc_d    = taken ? ucw.target : pc_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= S_INIT;
      busy_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      busy_q  <= busy_d;
      first_q <= first_d;
    end
  end

  assign ucw_o       = ucw;
  assign seq_o.busy  = busy_q;
  assign seq_o.first = first_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench of the modular exponentiation stream block.
// Depends on modexp_pkg and modular_exponentiation; predicts every plaintext
// beat with its own square-and-multiply model and checks it field by field.
`timescale 1ns / 1ps

module tb_top;
  import modexp_pkg::*;

  localparam int unsigned WORD_W         = ModWidthDefault;
  localparam int unsigned RANDOM_ITEMS   = 650;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 50;

  // register indexes that select no register
  localparam logic [CfgIdxW-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] plaintext;
    logic              last;
  } plain_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WORD_W-1:0]  cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [WORD_W-1:0]  s_tdata = '0;   // ciphertext
  logic               s_tlast = 1'b0; // last_item
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [WORD_W-1:0]  m_tdata;        // plaintext
  logic               m_tlast;        // last_out

  // shadow copies of the block's registers
  logic [WORD_W-1:0] exponent_sh = '0;
  logic [WORD_W-1:0] modulus_sh = 16'd2;

  plain_beat_t plain_expected_q[$];
  plain_beat_t plain_head;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pct = 0;

  always #5 clk = ~clk;

  modular_exponentiation u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  // right-to-left square and multiply at double width
  function automatic logic [WORD_W-1:0] mod_power(input logic [WORD_W-1:0] base,
                                                  input logic [WORD_W-1:0] ex,
                                                  input logic [WORD_W-1:0] m);
    logic [2*WORD_W-1:0] acc;
    logic [2*WORD_W-1:0] sq;
    logic [2*WORD_W-1:0] m_w;
    logic [WORD_W-1:0]   e;
    if (m < WORD_W'(2)) return '0;
    if (ex == '0) return WORD_W'(1);
    m_w = {{WORD_W{1'b0}}, m};
    sq  = {{WORD_W{1'b0}}, base} % m_w;
    acc = (2*WORD_W)'(1);
    e   = ex;
    while (e != '0) begin
      if (e[0]) acc = (acc * sq) % m_w;
      sq = (sq * sq) % m_w;
      e  = e >> 1;
    end
    return acc[WORD_W-1:0];
  endfunction

  // one register write beat, shadow follows on acceptance
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_EXPONENT: exponent_sh = value;
      REG_MODULUS:  modulus_sh = value;
      default: ;
    endcase
    // valid drops between write beats
    @(posedge clk);
  endtask

  // one ciphertext beat; bursts of random length with random gaps
  task automatic send_word(input logic [WORD_W-1:0] word, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(7, 0) == 0) ? $urandom_range(1500, 0) : $urandom_range(6, 0);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    plain_expected_q.push_back('{plaintext: mod_power(word, exponent_sh, modulus_sh),
                                 last: last});
  endtask

  // stop sending and wait for every expected beat
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (plain_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [WORD_W-1:0] ex, input logic [WORD_W-1:0] m);
    wait_idle();
    cfg_write(REG_EXPONENT, ex);
    cfg_write(REG_MODULUS, m);
  endtask

  // registers as they come out of reset
  task automatic test_reset_defaults();
    send_word(16'h0000, 1'b0);
    send_word(16'hffff, 1'b1);
  endtask

  task automatic test_zero_exponent();
    set_config(16'h0000, 16'hffff);
    send_word(16'h0000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hffff, 1'b1);
  endtask

  // all-ones operands and the smallest legal modulus
  task automatic test_full_width();
    set_config(16'hffff, 16'hffff);
    send_word(16'h0000, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hfffe, 1'b0);
    send_word(16'hffff, 1'b1);
    set_config(16'h0001, 16'hffff);
    send_word(16'h1234, 1'b0);
    send_word(16'hffff, 1'b1);
    set_config(16'hffff, 16'h0002);
    send_word(16'h0003, 1'b1);
  endtask

  // ciphertext at or above the modulus
  task automatic test_over_modulus();
    set_config(16'h0003, 16'h0007);
    send_word(16'h0064, 1'b0);
    send_word(16'h0007, 1'b0);
    send_word(16'hffff, 1'b1);
  endtask

  // modulus of one and of zero
  task automatic test_degenerate_modulus();
    set_config(16'h0000, 16'h0001);
    send_word(16'h0005, 1'b0);
    set_config(16'h0005, 16'h0001);
    send_word(16'h0007, 1'b1);
    set_config(16'h0000, 16'h0000);
    send_word(16'h0000, 1'b0);
    set_config(16'h0003, 16'h0000);
    send_word(16'hffff, 1'b1);
  endtask

  // writes to unused indexes leave both registers alone
  task automatic test_spare_index();
    set_config(16'h0003, 16'h000b);
    cfg_write(REG_SPARE2, 16'hffff);
    cfg_write(REG_SPARE3, 16'h0000);
    send_word(16'h0005, 1'b1);
  endtask

  // random settings per phase, messages of random words
  task automatic test_random_messages();
    int unsigned sent;
    int unsigned n;
    int unsigned phase_len;
    int unsigned msg_len;
    int unsigned pick;
    logic [WORD_W-1:0] ex;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] word;
    logic last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(9, 0);
      case (pick)
        0: ex = 16'h0000;
        1: ex = 16'h0001;
        2: ex = 16'hffff;
        3, 4, 5: ex = WORD_W'($urandom_range(255, 0));
        default: ex = WORD_W'($urandom);
      endcase
      pick = $urandom_range(11, 0);
      case (pick)
        0: m = 16'h0000;
        1: m = 16'h0001;
        2: m = 16'h0002;
        3: m = 16'hffff;
        4, 5: m = WORD_W'($urandom_range(255, 2));
        default: m = WORD_W'($urandom_range(65535, 2));
      endcase
      wait_idle();
      if ($urandom_range(1, 0) == 0) begin
        cfg_write(REG_EXPONENT, ex);
        cfg_write(REG_MODULUS, m);
      end else begin
        cfg_write(REG_MODULUS, m);
        cfg_write(REG_EXPONENT, ex);
      end
      phase_len = $urandom_range(60, 15);
      n = 0;
      while (n < phase_len) begin
        msg_len = $urandom_range(8, 1);
        for (int unsigned i = 0; i < msg_len; i++) begin
          pick = $urandom_range(7, 0);
          if (pick == 6 && modulus_sh >= 2) begin
            word = WORD_W'($urandom_range(modulus_sh - 1, 0));
          end else if (pick == 7) begin
            case ($urandom_range(4, 0))
              0: word = 16'h0000;
              1: word = 16'h0001;
              2: word = modulus_sh - WORD_W'(1);
              3: word = modulus_sh;
              default: word = 16'hffff;
            endcase
          end else begin
            word = WORD_W'($urandom);
          end
          // mostly well-formed messages, some stray last flags
          if ($urandom_range(7, 0) == 0) last = 1'($urandom_range(1, 0));
          else last = (i == msg_len - 1);
          send_word(word, last);
          n++;
          sent++;
        end
      end
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (plain_expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got plaintext %h last %b",
                 $time, m_tdata, m_tlast);
        mismatch_cnt++;
      end else begin
        plain_head = plain_expected_q.pop_front();
        if (m_tdata !== plain_head.plaintext) begin
          $display("%0t: plaintext mismatch, expected %h, got %h",
                   $time, plain_head.plaintext, m_tdata);
          mismatch_cnt++;
        end
        if (m_tlast !== plain_head.last) begin
          $display("%0t: last mismatch, expected %b, got %b",
                   $time, plain_head.last, m_tlast);
          mismatch_cnt++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_left = $urandom_range(400, 50);
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end else begin
      stall_left--;
    end
    m_tready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // cycles since the last beat on any channel
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_exponent();
    test_full_width();
    test_over_modulus();
    test_degenerate_modulus();
    test_spare_index();
    test_random_messages();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && plain_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
